/* src/reliable_multicast_ack_tracker_assert.svh */
// ----------------------------------------------------------------------------
// assertion macros for the multicast acknowledgment tracker
// clocked on clk_i, disabled while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef RELIABLE_MULTICAST_ACK_TRACKER_ASSERT_SVH
`define RELIABLE_MULTICAST_ACK_TRACKER_ASSERT_SVH

// same-cycle implication
`define RMAT_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rmat assertion failed");

// next-cycle implication
`define RMAT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rmat assertion failed");

`endif

/* src/rmat_pkg.sv */
// ----------------------------------------------------------------------------
// rmat_pkg
// shared types and codes of the multicast acknowledgment tracker
// ----------------------------------------------------------------------------
`default_nettype none

package rmat_pkg;

  localparam int unsigned MAX_DESTS = 16;
  localparam int unsigned MAX_PARTS = 256;
  localparam int unsigned SLOT_W    = 4;
  localparam int unsigned ID_W      = 16;
  localparam int unsigned LEN_W     = 16;
  localparam int unsigned CNT_W     = 9;
  localparam int unsigned DC_W      = 5;

  // commands
  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_ACK   = 2'd1;
  localparam logic [1:0] CMD_QUERY = 2'd2;
  localparam logic [1:0] CMD_NOP   = 2'd3;

  // result status
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_INVALID = 3'd1;
  localparam logic [2:0] ST_IGNORED = 3'd2;
  localparam logic [2:0] ST_NOTHING = 3'd3;
  localparam logic [2:0] ST_TOOLONG = 3'd4;

  // configuration register indexes
  localparam logic [1:0] REG_DEST_COUNT  = 2'd0;
  localparam logic [1:0] REG_PAYLOAD_LEN = 2'd1;
  localparam logic [1:0] REG_LINK_MAX    = 2'd2;

  // derived message geometry
  typedef struct packed {
    logic             ok;
    logic [CNT_W-1:0] count;
    logic [LEN_W-1:0] size;
    logic [LEN_W-1:0] last;
  } geom_t;

endpackage

`default_nettype wire

/* src/rmat_row_mem.sv */
// ----------------------------------------------------------------------------
// rmat_row_mem
// one-write one-read synchronous memory holding one row per message part
// ----------------------------------------------------------------------------
`default_nettype none

module rmat_row_mem #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = 8,
  parameter int unsigned W     = 21
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [W-1:0]  wdata_i,
  input  wire logic          re_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic      [W-1:0]  rdata_o
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

/* src/rmat_geom.sv */
// ----------------------------------------------------------------------------
// rmat_geom
// part size and part count from the configuration, bit-serial divider
// ----------------------------------------------------------------------------
`default_nettype none

module rmat_geom #(
  parameter int unsigned OUTER_HEADER_BYTES = 16,
  parameter int unsigned INNER_HEADER_BYTES = 8
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [rmat_pkg::DC_W-1:0]   dest_count_i,
  input  wire logic [rmat_pkg::LEN_W-1:0]  payload_i,
  input  wire logic [rmat_pkg::LEN_W-1:0]  link_max_i,
  output logic                             busy_o,
  output rmat_pkg::geom_t                  geom_o
);

  localparam int unsigned LW = rmat_pkg::LEN_W;
  localparam logic [LW:0] HDR = (LW+1)'(OUTER_HEADER_BYTES + INNER_HEADER_BYTES);
  localparam logic [LW:0] PARTS_MAX = (LW+1)'(rmat_pkg::MAX_PARTS);

  logic          pend_q, busy_q;
  logic [4:0]    cnt_q;
  logic [LW:0]   rem_q;
  logic [LW-1:0] quo_q;

  logic [LW:0]   overhead;
  logic          dc_ok, ov_ok;
  logic [LW-1:0] ps;
  logic [LW:0]   rem_sh;
  logic          ge;
  logic [LW:0]   pc_raw, pc;
  rmat_pkg::geom_t geom_d;

  assign overhead = HDR + {(LW-rmat_pkg::DC_W)'(0), dest_count_i, 1'b0};
  assign dc_ok    = (dest_count_i != '0) &&
                    ({1'b0, dest_count_i} <= (rmat_pkg::DC_W+1)'(rmat_pkg::MAX_DESTS));
  assign ov_ok    = overhead < {1'b0, link_max_i};
  assign ps       = link_max_i - overhead[LW-1:0];
  assign rem_sh   = {rem_q[LW-1:0], quo_q[LW-1]};
  assign ge       = rem_sh >= {1'b0, ps};
  assign pc_raw   = {1'b0, quo_q} + (LW+1)'(rem_q != '0);
  // an empty payload still makes one part
  assign pc       = (pc_raw == '0) ? (LW+1)'(1) : pc_raw;

  always_comb begin
    geom_d.ok    = dc_ok && ov_ok && (pc <= PARTS_MAX);
    geom_d.count = geom_d.ok ? pc[rmat_pkg::CNT_W-1:0] : '0;
    geom_d.size  = ps;
    if (pc == (LW+1)'(1)) begin
      geom_d.last = payload_i;
    end else if (rem_q == '0) begin
      geom_d.last = ps;
    end else begin
      geom_d.last = rem_q[LW-1:0];
    end
  end

  // a write marks the result stale; the run starts once the register holds it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b1;
      busy_q <= 1'b0;
      cnt_q  <= '0;
      geom_o <= '0;
    end else begin
      if (start_i) begin
        pend_q <= 1'b1;
        busy_q <= 1'b0;
      end else if (pend_q) begin
        pend_q <= 1'b0;
        busy_q <= dc_ok && ov_ok;
        cnt_q  <= 5'(LW);
        if (!(dc_ok && ov_ok)) begin
          geom_o <= '0;
        end
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          geom_o <= geom_d;
        end else begin
          cnt_q <= cnt_q - 5'd1;
        end
      end
    end
  end

  // dividend shifts out while the quotient shifts in
  always_ff @(posedge clk_i) begin
    if (pend_q) begin
      rem_q <= '0;
      quo_q <= payload_i;
    end else if (busy_q && cnt_q != '0) begin
      rem_q <= ge ? (rem_sh - {1'b0, ps}) : rem_sh;
      quo_q <= {quo_q[LW-2:0], ge};
    end
  end

  assign busy_o = pend_q || busy_q || start_i;

endmodule

`default_nettype wire

/* src/reliable_multicast_ack_tracker.sv */
// ----------------------------------------------------------------------------
// reliable_multicast_ack_tracker
// delivery tracking of one segmented message to up to sixteen destinations
// ----------------------------------------------------------------------------
// usage:
//   cfg channel writes dest_count, payload_length and link_max_length; each
//   write restarts a bit-serial divider that derives part size and part count
//   and the input channel stalls until it is done
//   s_axis carries load, acknowledge and query items; m_axis returns exactly
//   one result per item (none for the unused command code)
//   an item is taken with a read of its part row from the row memory, then
//   the row is modified, written back and the result registered; the block
//   takes no new item until the one before it is through
//   reset and every load to slot 0 start a clearing pass over all MAX_PARTS
//   rows, one row a cycle, during which no item is taken
//   a stalled m_axis holds its result; the block takes the next item, reads
//   its row and waits before the write-back until the output register frees
// ----------------------------------------------------------------------------
`default_nettype none

`include "reliable_multicast_ack_tracker_assert.svh"

module reliable_multicast_ack_tracker #(
  parameter int unsigned OUTER_HEADER_BYTES = 16,
  parameter int unsigned INNER_HEADER_BYTES = 8
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration write
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i,
  // items in
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [55:0] s_axis_tdata,  // dest_slot, client_id, part_index, length_limit
  input  wire logic [1:0]  s_axis_tuser,  // command
  // results out
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // pending_mask, first_destination, is_multicast, message_length,
  // part_count, parts_pending, client_parts_pending
  output logic [79:0]      m_axis_tdata,
  output logic [2:0]       m_axis_tuser   // status
);

  localparam int unsigned MP = rmat_pkg::MAX_PARTS;
  localparam int unsigned AW = (MP > 1) ? $clog2(MP) : 1;
  localparam int unsigned ND = rmat_pkg::MAX_DESTS;
  localparam int unsigned CW = rmat_pkg::CNT_W;
  localparam int unsigned DW = rmat_pkg::DC_W;
  localparam int unsigned RW = DW + ND;
  localparam logic [AW-1:0] LAST_ROW = AW'(MP - 1);
  localparam logic [17:0] HDR = 18'(OUTER_HEADER_BYTES + INNER_HEADER_BYTES);

  // states
  localparam logic [1:0] S_SWEEP = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_EXEC  = 2'd2;

  logic [1:0] state_q, state_d;
  logic [AW-1:0] sweep_q;
  logic [DW-1:0] fill_q;

  // configuration
  logic [DW-1:0] dest_count_q;
  logic [15:0]   payload_q, link_q;
  logic          cfg_wr;
  rmat_pkg::geom_t geom;
  logic          geo_busy;

  // latched item
  logic [1:0]  cmd_q;
  logic [3:0]  slot_q;
  logic [15:0] cid_q, pidx_q, limit_q;

  // destination table and counters
  logic [15:0]   ids_q [ND];
  logic [CW-1:0] ccnt_q [ND];
  logic [CW-1:0] total_q;

  // row memory: {part pending count, received bitmap}
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr;
  logic [RW-1:0] mem_wdata, mem_rdata;
  logic [DW-1:0] row_cnt;
  logic [ND-1:0] row_bm;

  // output register
  logic        out_valid_q;
  logic [2:0]  o_status_q;
  logic [15:0] o_mask_q, o_first_q, o_len_q;
  logic        o_multi_q;
  logic [CW-1:0] o_pc_q, o_pp_q, o_cpp_q;
  logic        out_load, out_free;

  // result compute
  logic [2:0]  r_status;
  logic [15:0] r_mask, r_first, r_len;
  logic        r_multi;
  logic [CW-1:0] r_pc, r_pp, r_cpp;
  logic        found;
  logic [3:0]  who;
  logic [ND-1:0] active, pend;
  logic [4:0]  npend;
  logic [3:0]  first_idx;
  logic        have;
  logic        in_range, is_last;
  logic [17:0] len;
  logic        ack_ok;
  logic [DW-1:0] cnt_dec;
  logic [CW-1:0] ccnt_dec, total_new;
  logic        clear;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dest_count_q <= DW'(1);
      payload_q    <= '0;
      link_q       <= 16'd1024;
    end else if (cfg_wr) begin
      case (cfg_index_i)
        rmat_pkg::REG_DEST_COUNT:  dest_count_q <= cfg_data_i[DW-1:0];
        rmat_pkg::REG_PAYLOAD_LEN: payload_q    <= cfg_data_i;
        rmat_pkg::REG_LINK_MAX:    link_q       <= cfg_data_i;
        default: ;
      endcase
    end
  end

  rmat_geom #(
    .OUTER_HEADER_BYTES (OUTER_HEADER_BYTES),
    .INNER_HEADER_BYTES (INNER_HEADER_BYTES)
  ) u_geom (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (cfg_wr),
    .dest_count_i (dest_count_q),
    .payload_i    (payload_q),
    .link_max_i   (link_q),
    .busy_o       (geo_busy),
    .geom_o       (geom)
  );

  assign s_axis_tready = (state_q == S_IDLE) && !geo_busy;

  // read the part row as the item is taken
  assign mem_re = s_axis_tvalid && s_axis_tready;

  rmat_row_mem #(
    .DEPTH (MP),
    .AW    (AW),
    .W     (RW)
  ) u_rows (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (s_axis_tdata[20+AW-1:20]),
    .rdata_o (mem_rdata)
  );

  assign row_cnt = mem_rdata[RW-1:ND];
  assign row_bm  = mem_rdata[ND-1:0];

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      cmd_q   <= s_axis_tuser;
      slot_q  <= s_axis_tdata[3:0];
      cid_q   <= s_axis_tdata[19:4];
      pidx_q  <= s_axis_tdata[35:20];
      limit_q <= s_axis_tdata[51:36];
    end
  end

  // slot lookup: highest matching slot in use wins
  always_comb begin
    found = 1'b0;
    who   = '0;
    for (int i = 0; i < ND; i++) begin
      active[i] = (DW+1)'(i) < {1'b0, dest_count_q};
      if (active[i] && ids_q[i] == cid_q) begin
        found = 1'b1;
        who   = 4'(i);
      end
    end
  end

  // pending destinations of the row, lowest one first
  always_comb begin
    pend      = ~row_bm & active;
    npend     = '0;
    have      = 1'b0;
    first_idx = '0;
    for (int i = 0; i < ND; i++) begin
      npend = npend + 5'(pend[i]);
      if (pend[i] && !have) begin
        have      = 1'b1;
        first_idx = 4'(i);
      end
    end
  end

  assign in_range = pidx_q < {7'b0, geom.count};
  assign is_last  = pidx_q == ({7'b0, geom.count} - 16'd1);
  assign len = HDR + {2'b0, (is_last ? geom.last : geom.size)} +
               ((npend > 5'd1) ? {12'b0, npend, 1'b0} : 18'd0);

  assign ack_ok   = found && in_range && !row_bm[who];
  assign cnt_dec  = (row_cnt != '0) ? row_cnt - DW'(1) : row_cnt;
  assign ccnt_dec = (ccnt_q[who] != '0) ? ccnt_q[who] - CW'(1) : ccnt_q[who];
  assign total_new = (row_cnt == DW'(1) && total_q != '0) ? total_q - CW'(1) : total_q;

  assign out_free = !out_valid_q || m_axis_tready;
  assign out_load = (state_q == S_EXEC) && (cmd_q != rmat_pkg::CMD_NOP) && out_free;
  assign clear    = out_load && (cmd_q == rmat_pkg::CMD_LOAD) && (slot_q == '0);

  always_comb begin
    r_status = rmat_pkg::ST_OK;
    r_mask   = '0;
    r_first  = '0;
    r_multi  = 1'b0;
    r_len    = '0;
    r_pc     = geom.count;
    r_pp     = total_q;
    r_cpp    = '0;
    case (cmd_q)
      rmat_pkg::CMD_LOAD: begin
        if (slot_q == '0) begin
          r_pp = geom.count;
        end
      end
      rmat_pkg::CMD_ACK: begin
        if (!geom.ok) begin
          r_status = rmat_pkg::ST_INVALID;
          r_pp     = '0;
        end else if (!ack_ok) begin
          r_status = rmat_pkg::ST_IGNORED;
          r_cpp    = found ? ccnt_q[who] : '0;
        end else begin
          r_pp  = total_new;
          r_cpp = ccnt_dec;
        end
      end
      rmat_pkg::CMD_QUERY: begin
        if (!geom.ok) begin
          r_status = rmat_pkg::ST_INVALID;
          r_pp     = '0;
        end else if (!in_range || row_cnt == '0 || npend == '0) begin
          r_status = rmat_pkg::ST_NOTHING;
        end else begin
          r_status = (limit_q != '0 && len > {2'b0, limit_q}) ?
                     rmat_pkg::ST_TOOLONG : rmat_pkg::ST_OK;
          r_mask   = pend;
          r_first  = ids_q[first_idx];
          r_multi  = npend > 5'd1;
          r_len    = len[15:0];
        end
      end
      default: ;
    endcase
  end

  // row write port: clearing pass or acknowledged part
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = sweep_q;
    mem_wdata = {fill_q, {ND{1'b0}}};
    if (state_q == S_SWEEP) begin
      mem_we = 1'b1;
    end else if (out_load && cmd_q == rmat_pkg::CMD_ACK && geom.ok && ack_ok) begin
      mem_we    = 1'b1;
      mem_waddr = pidx_q[AW-1:0];
      mem_wdata = {cnt_dec, row_bm | (ND'(1) << who)};
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_SWEEP: if (sweep_q == LAST_ROW) state_d = S_IDLE;
      S_IDLE:  if (mem_re) state_d = S_EXEC;
      S_EXEC: begin
        if (cmd_q == rmat_pkg::CMD_NOP) begin
          state_d = S_IDLE;
        end else if (out_free) begin
          state_d = clear ? S_SWEEP : S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_SWEEP;
      sweep_q <= '0;
      fill_q  <= '0;
      total_q <= '0;
      for (int i = 0; i < ND; i++) begin
        ccnt_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (state_q == S_SWEEP) begin
        sweep_q <= (sweep_q == LAST_ROW) ? '0 : sweep_q + AW'(1);
      end
      if (clear) begin
        fill_q  <= dest_count_q;
        sweep_q <= '0;
        total_q <= geom.count;
        for (int i = 0; i < ND; i++) begin
          ccnt_q[i] <= geom.count;
        end
      end else if (mem_we && state_q == S_EXEC) begin
        total_q     <= total_new;
        ccnt_q[who] <= ccnt_dec;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load && cmd_q == rmat_pkg::CMD_LOAD) begin
      ids_q[slot_q] <= cid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      o_status_q <= r_status;
      o_mask_q   <= r_mask;
      o_first_q  <= r_first;
      o_multi_q  <= r_multi;
      o_len_q    <= r_len;
      o_pc_q     <= r_pc;
      o_pp_q     <= r_pp;
      o_cpp_q    <= r_cpp;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = o_status_q;
  assign m_axis_tdata  = {4'b0, o_cpp_q, o_pp_q, o_pc_q, o_len_q, o_multi_q,
                          o_first_q, o_mask_q};

  `RMAT_ASSERT_IMPL(a_no_take_in_sweep, state_q == S_SWEEP, !s_axis_tready)
  `RMAT_ASSERT_IMPL(a_no_write_when_idle, state_q == S_IDLE, !mem_we)
  `RMAT_ASSERT_NEXT(a_take_goes_exec, s_axis_tvalid && s_axis_tready, state_q == S_EXEC)
  `RMAT_ASSERT_NEXT(a_total_falls, state_q == S_EXEC && cmd_q != rmat_pkg::CMD_LOAD,
                    total_q <= $past(total_q))

endmodule

`default_nettype wire

/* dv/tb.sv */
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the multicast acknowledgment tracker: a delivery
// board predicts each result from the accepted items and the written
// registers, and the results are compared field by field in arrival order
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

  typedef struct {
    logic [2:0]  status;
    logic [15:0] mask;
    logic [15:0] first;
    logic        multi;
    logic [15:0] len;
    logic [8:0]  parts;
    logic [8:0]  pending;
    logic [8:0]  client_pending;
  } answer_t;

  // predicted tracker state and the queue of answers still due
  class delivery_board;
    int unsigned dest_cnt = 1;
    int unsigned payload  = 0;
    int unsigned link_max = 1024;
    logic [15:0] ids [16];
    logic [15:0] got_rows [256];
    int unsigned row_left [256];
    int unsigned client_left [16];
    int unsigned total_left;
    answer_t     due [$];
    int          errors;

    function new();
      foreach (ids[i]) ids[i] = '0;
      foreach (got_rows[i]) begin
        got_rows[i] = '0;
        row_left[i] = 0;
      end
      foreach (client_left[i]) client_left[i] = 0;
      total_left = 0;
      errors = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [15:0] val);
      case (idx)
        rmat_pkg::REG_DEST_COUNT:  dest_cnt = 32'(val[4:0]);
        rmat_pkg::REG_PAYLOAD_LEN: payload  = 32'(val);
        rmat_pkg::REG_LINK_MAX:    link_max = 32'(val);
        default: ;
      endcase
    endfunction

    // part size and part count; 0 when the settings are unusable
    function bit geometry(output int unsigned size, output int unsigned count);
      int unsigned ovh;
      size = 0;
      count = 0;
      if (dest_cnt == 0 || dest_cnt > rmat_pkg::MAX_DESTS) return 0;
      ovh = 24 + 2 * dest_cnt;
      if (ovh >= link_max) return 0;
      size = link_max - ovh;
      count = (payload + size - 1) / size;
      if (count == 0) count = 1;
      if (count > 256) begin
        count = 0;
        return 0;
      end
      return 1;
    endfunction

    function void note(logic [1:0] cmd, logic [3:0] slot, logic [15:0] cid,
                       logic [15:0] pidx, logic [15:0] limit);
      answer_t     a;
      int unsigned size, count, who, npend, bytes, len, pc;
      bit          ok, found;
      a = '{default: '0};
      ok = geometry(size, count);
      if (cmd == rmat_pkg::CMD_NOP) return;
      if (cmd == rmat_pkg::CMD_LOAD) begin
        ids[slot] = cid;
        if (slot == 0) begin
          pc = ok ? count : 0;
          foreach (got_rows[i]) begin
            got_rows[i] = '0;
            row_left[i] = dest_cnt & 8'hFF;
          end
          foreach (client_left[i]) client_left[i] = pc;
          total_left = pc;
        end
        a.parts = 9'(ok ? count : 0);
        a.pending = 9'(total_left);
      end else if (!ok) begin
        a.status = rmat_pkg::ST_INVALID;
      end else if (cmd == rmat_pkg::CMD_ACK) begin
        a.parts = 9'(count);
        found = 0;
        who = 0;
        for (int i = 0; i < dest_cnt; i++)
          if (ids[i] == cid) begin
            found = 1;
            who = i;
          end
        if (!found || pidx >= count || got_rows[pidx][who]) begin
          a.status = rmat_pkg::ST_IGNORED;
          a.pending = 9'(total_left);
          a.client_pending = 9'(found ? client_left[who] : 0);
        end else begin
          got_rows[pidx][who] = 1'b1;
          if (row_left[pidx] > 0) begin
            row_left[pidx]--;
            if (row_left[pidx] == 0 && total_left > 0) total_left--;
          end
          if (client_left[who] > 0) client_left[who]--;
          a.pending = 9'(total_left);
          a.client_pending = 9'(client_left[who]);
        end
      end else begin
        a.parts = 9'(count);
        a.pending = 9'(total_left);
        npend = 0;
        if (pidx < count && row_left[pidx] != 0) begin
          for (int i = dest_cnt - 1; i >= 0; i--)
            if (!got_rows[pidx][i]) begin
              a.mask[i] = 1'b1;
              a.first = ids[i];
              npend++;
            end
        end
        if (npend == 0) begin
          a.status = rmat_pkg::ST_NOTHING;
          a.mask = '0;
          a.first = '0;
        end else begin
          if (count == 1) bytes = payload;
          else if (pidx < count - 1) bytes = size;
          else bytes = payload - (count - 1) * size;
          len = 24 + bytes + ((npend > 1) ? 2 * npend : 0);
          a.status = (limit > 0 && len > limit) ? rmat_pkg::ST_TOOLONG : rmat_pkg::ST_OK;
          a.multi = npend > 1;
          a.len = len[15:0];
        end
      end
      due.insert(due.size(), a);
    endfunction

    function void cmp(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
    endfunction

    function void check(logic [2:0] st, logic [79:0] d);
      answer_t a;
      if (due.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual status %0h data %h",
                 $time, st, d);
        return;
      end
      a = due.pop_front();
      cmp("status", a.status, st);
      cmp("pending_mask", a.mask, d[15:0]);
      cmp("first_destination", a.first, d[31:16]);
      cmp("is_multicast", a.multi, d[32]);
      cmp("message_length", a.len, d[48:33]);
      cmp("part_count", a.parts, d[57:49]);
      cmp("parts_pending", a.pending, d[66:58]);
      cmp("client_parts_pending", a.client_pending, d[75:67]);
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata = '0;  // dest_slot, client_id, part_index, length_limit
  logic [1:0]  s_axis_tuser = '0;  // command
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // pending_mask, first_destination, is_multicast, message_length,
  // part_count, parts_pending, client_parts_pending
  logic [79:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;       // status

  delivery_board board = new();
  int          idle_pct = 0;
  int          stall_pct = 0;
  int          hold_left = 0;
  int          hold_len = 0;
  bit          hold_tog = 1'b0;
  bit          hold_seen = 1'b0;

  reliable_multicast_ack_tracker u_dut (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // result side: random stalls, plus a long hold-off when one is requested
  always @(posedge clk_i) begin
    if (hold_tog != hold_seen) begin
      hold_seen <= hold_tog;
      hold_left <= hold_len;
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
    if (m_axis_tvalid && m_axis_tready) board.check(m_axis_tuser, m_axis_tdata);
  end

  initial begin
    #(4 * 2000000);
    $display("TEST FAILED");
    $finish;
  end

  task automatic send(logic [1:0] cmd, logic [3:0] slot, logic [15:0] cid,
                      logic [15:0] pidx, logic [15:0] limit);
    if ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {4'b0, limit, pidx, cid, slot};
    do @(posedge clk_i); while (!s_axis_tready);
    board.note(cmd, slot, cid, pidx, limit);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (board.due.size() != 0) @(posedge clk_i);
    // a trailing unused command or a clearing pass may still be in flight
    repeat (300) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    board.set_reg(idx, val);
  endtask

  // mostly well-formed acks and queries for loaded clients, some noise
  task automatic random_items(int n);
    int unsigned size, count, r, s;
    logic [15:0] p, lim;
    bit          ok;
    for (int k = 0; k < n; k++) begin
      ok = board.geometry(size, count);
      r = $urandom_range(99);
      s = (board.dest_cnt >= 1 && board.dest_cnt <= 16) ?
          $urandom_range(board.dest_cnt - 1) : $urandom_range(15);
      p = (ok && $urandom_range(9) != 0) ? 16'($urandom_range(count - 1)) :
          16'($urandom());
      case ($urandom_range(3))
        0, 1:    lim = '0;
        2:       lim = 16'($urandom_range(20, 400));
        default: lim = 16'($urandom());
      endcase
      if (r < 50)      send(rmat_pkg::CMD_ACK, 4'($urandom()), board.ids[s], p,
                            16'($urandom()));
      else if (r < 80) send(rmat_pkg::CMD_QUERY, 4'($urandom()), 16'($urandom()), p, lim);
      else if (r < 88) send(2'($urandom_range(1, 2)), 4'($urandom()), 16'($urandom()),
                            16'($urandom()), 16'($urandom()));
      else if (r < 95) send(rmat_pkg::CMD_LOAD, 4'($urandom_range(1, 15)),
                            $urandom_range(1) ? board.ids[$urandom_range(15)] :
                            16'($urandom()),
                            16'($urandom()), 16'($urandom()));
      else if (r < 98) send(rmat_pkg::CMD_NOP, 4'($urandom()), 16'($urandom()),
                            16'($urandom()), 16'($urandom()));
      else             send(rmat_pkg::CMD_LOAD, 4'd0, 16'($urandom()), 16'($urandom()),
                            16'($urandom()));
    end
  endtask

  task automatic phase(int dc, int pl, int lk, int idle, int stall, int hold,
                       bit clear, int n);
    drain();
    write_reg(rmat_pkg::REG_DEST_COUNT, 16'(dc));
    write_reg(rmat_pkg::REG_PAYLOAD_LEN, 16'(pl));
    write_reg(rmat_pkg::REG_LINK_MAX, 16'(lk));
    idle_pct = idle;
    stall_pct = stall;
    if (hold > 0) begin
      hold_len = hold;
      hold_tog = !hold_tog;
    end
    if (clear) send(rmat_pkg::CMD_LOAD, 4'd0, board.ids[0], 16'($urandom()),
                    16'($urandom()));
    random_items(n);
  endtask

  initial begin
    logic [15:0] id0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // load every slot first so no unwritten slot is ever read
    send(rmat_pkg::CMD_LOAD, 4'd0, 16'h0000, 16'hFFFF, 16'hFFFF);
    send(rmat_pkg::CMD_LOAD, 4'd15, 16'hFFFF, 16'h0000, 16'h0000);
    for (int i = 1; i < 15; i++)
      send(rmat_pkg::CMD_LOAD, 4'(i), 16'($urandom()), 16'($urandom()), 16'($urandom()));
    id0 = board.ids[0];
    // single destination, empty payload: too long, fine, delivered, repeats
    send(rmat_pkg::CMD_QUERY, 4'd0, 16'd0, 16'd0, 16'd1);
    send(rmat_pkg::CMD_QUERY, 4'd0, 16'd0, 16'd0, 16'd0);
    send(rmat_pkg::CMD_QUERY, 4'd0, 16'd0, 16'hFFFF, 16'd0);
    send(rmat_pkg::CMD_ACK, 4'd0, id0 ^ 16'h8001, 16'd0, 16'd0);
    send(rmat_pkg::CMD_ACK, 4'd0, id0, 16'hFFFF, 16'd0);
    send(rmat_pkg::CMD_ACK, 4'd0, id0, 16'd0, 16'd0);
    send(rmat_pkg::CMD_ACK, 4'd0, id0, 16'd0, 16'd0);
    send(rmat_pkg::CMD_QUERY, 4'd0, 16'd0, 16'd0, 16'd0);
    send(rmat_pkg::CMD_NOP, 4'hF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    drain();
    // unusable link size: acks and queries refused, loads still answered
    write_reg(rmat_pkg::REG_LINK_MAX, 16'd0);
    send(rmat_pkg::CMD_ACK, 4'd0, id0, 16'd0, 16'd0);
    send(rmat_pkg::CMD_QUERY, 4'd0, 16'd0, 16'd0, 16'd0);
    send(rmat_pkg::CMD_LOAD, 4'd3, board.ids[3], 16'd0, 16'd0);

    phase(4, 3000, 1024, 0, 0, 0, 1, 100);
    phase(16, 2000, 200, 57, 0, 0, 1, 100);
    phase(8, 500, 100, 0, 57, 0, 1, 100);
    phase(16, 65535, 65535, 17, 17, 0, 1, 60);
    phase(16, 65535, 312, 0, 0, 300, 1, 100);   // 256 parts, output held off
    phase(3, 100, 80, 17, 17, 0, 0, 60);        // counters left from before
    phase(2, 0, 65535, 0, 0, 0, 1, 80);
    phase(16, 65535, 300, 0, 0, 0, 1, 30);      // too many parts
    phase(0, 100, 1024, 57, 57, 0, 1, 20);
    phase(31, 100, 1024, 0, 0, 0, 1, 20);
    phase(16, 1000, 56, 0, 0, 0, 1, 20);        // header fills the link
    phase(5, 1234, 500, 57, 0, 0, 1, 100);
    phase(12, 4000, 1500, 0, 57, 0, 1, 100);
    phase(1, 50, 40, 17, 17, 0, 1, 100);
    drain();

    if (board.due.size() != 0) begin
      board.errors++;
      $display("%0t: %0d results never arrived", $time, board.due.size());
    end
    if (board.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* filelist.f */
+incdir+src
src/rmat_pkg.sv
src/rmat_row_mem.sv
src/rmat_geom.sv
src/reliable_multicast_ack_tracker.sv
dv/tb.sv
